// ----- rtl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types, constants and helpers of the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int BYTE_W         = 8;
	localparam int SIZE_W         = 32;
	localparam int LEN_W          = 32;
	localparam int OUT_TDATA_W    = 48;
	localparam int OQ_DEPTH       = 4;
	localparam int OQ_AW          = $clog2(OQ_DEPTH);

	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] payload;
		logic              status;
		logic [LEN_W-1:0]  length;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.value = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

// ----- rtl/hcbd_core.sv -----
// ----------------------------------------------------------------------------
// hcbd_core
// header / data / trailer parser state and one-step result generation
// ----------------------------------------------------------------------------
module hcbd_core import hcbd_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [BYTE_W-1:0] body_byte,
	input  logic              byte_present,
	input  logic              end_of_body,
	output push_t             push
);

	localparam logic [2:0] PH_HDR_START  = 3'd0;
	localparam logic [2:0] PH_HDR_DIGITS = 3'd1;
	localparam logic [2:0] PH_EXT        = 3'd2;
	localparam logic [2:0] PH_DATA       = 3'd3;
	localparam logic [2:0] PH_TRAIL      = 3'd4;
	localparam logic [2:0] PH_TRAIL_CR   = 3'd5;
	localparam logic [2:0] PH_DONE       = 3'd6;
	localparam logic [2:0] PH_ERROR      = 3'd7;

	logic [2:0]            phase_q, phase_nx;
	logic [SIZE_W-1:0]     size_q, size_nx;
	logic [SIZE_W-1:0]     left_q, left_nx;
	logic [COUNT_BITS-1:0] cnt_q, cnt_nx;
	logic                  emit_pay;
	logic                  status;
	hex_t                  hx;
	res_t                  pay_r, stat_r;

	always_comb begin
		hx       = hex_decode(body_byte);
		phase_nx = phase_q;
		size_nx  = size_q;
		left_nx  = left_q;
		emit_pay = 1'b0;
		if (byte_present) begin
			unique case (phase_q)
				PH_HDR_START: begin
					phase_nx = hx.valid ? PH_HDR_DIGITS : PH_ERROR;
					size_nx  = hx.valid ? SIZE_W'(hx.value) : size_q;
				end
				PH_HDR_DIGITS: begin
					if (body_byte == CH_CR || body_byte == CH_SEMI) begin
						phase_nx = PH_EXT;
					end else if (!hx.valid) begin
						phase_nx = PH_ERROR;
					end else begin
						size_nx = {size_q[SIZE_W-5:0], hx.value};
					end
				end
				PH_EXT: begin
					if (body_byte == CH_LF) begin
						if (size_q == '0) begin
							phase_nx = PH_DONE;
						end else begin
							left_nx  = size_q;
							phase_nx = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					left_nx  = left_q - SIZE_W'(1);
					emit_pay = 1'b1;
					if (left_q == SIZE_W'(1)) begin
						phase_nx = PH_TRAIL;
					end
				end
				PH_TRAIL: begin
					if (body_byte == CH_CR) begin
						phase_nx = PH_TRAIL_CR;
					end else begin
						phase_nx = hx.valid ? PH_HDR_DIGITS : PH_ERROR;
						size_nx  = hx.valid ? SIZE_W'(hx.value) : size_q;
					end
				end
				PH_TRAIL_CR: begin
					phase_nx = (body_byte == CH_LF) ? PH_HDR_START : PH_ERROR;
				end
				PH_DONE, PH_ERROR: begin
				end
				default: begin
				end
			endcase
		end
		cnt_nx = cnt_q + COUNT_BITS'(emit_pay);
		unique case (phase_nx) inside
			PH_HDR_START, PH_TRAIL, PH_DONE: status = 1'b0;
			PH_HDR_DIGITS, PH_EXT:           status = (size_nx != '0);
			default:                         status = 1'b1;
		endcase
	end

	always_comb begin
		pay_r.kind    = KIND_PAYLOAD;
		pay_r.payload = body_byte;
		pay_r.status  = 1'b0;
		pay_r.length  = '0;
		pay_r.last    = 1'b0;

		stat_r.kind    = KIND_STATUS;
		stat_r.payload = '0;
		stat_r.status  = status;
		stat_r.length  = LEN_W'(cnt_nx);
		stat_r.last    = 1'b1;

		push.n  = fire ? (2'(emit_pay) + 2'(end_of_body)) : 2'd0;
		push.r0 = emit_pay ? pay_r : stat_r;
		push.r1 = stat_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_START;
			size_q  <= '0;
			left_q  <= '0;
			cnt_q   <= '0;
		end else if (fire) begin
			if (end_of_body) begin
				phase_q <= PH_HDR_START;
				size_q  <= '0;
				left_q  <= '0;
				cnt_q   <= '0;
			end else begin
				phase_q <= phase_nx;
				size_q  <= size_nx;
				left_q  <= left_nx;
				cnt_q   <= cnt_nx;
			end
		end
	end

	a_eob_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_body |=> phase_q == PH_HDR_START && cnt_q == '0)
		else $error("state not cleared after end of body");

	a_data_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("data phase with no bytes left");

	a_payload_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		emit_pay |-> phase_q == PH_DATA && byte_present)
		else $error("payload emitted outside chunk data");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !end_of_body |=> cnt_q == $past(cnt_q) + COUNT_BITS'($past(emit_pay)))
		else $error("payload count off");

endmodule

// ----- rtl/hcbd_outq.sv -----
// ----------------------------------------------------------------------------
// hcbd_outq
// result queue, takes up to two results per cycle and delivers one
// ----------------------------------------------------------------------------
module hcbd_outq import hcbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t              mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  wr_q, rd_q;
	logic [OQ_AW:0]    cnt_q;
	logic              pop;

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + OQ_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OQ_AW'(push.n);
			rd_q  <= rd_q + OQ_AW'(pop);
			cnt_q <= cnt_q + (OQ_AW+1)'(push.n) - (OQ_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (OQ_AW+1)'(OQ_DEPTH))
		else $error("result queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push without room");

	a_no_triple: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3)
		else $error("illegal push count");

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// path: a result passes the input stage register and then the result queue
// throughput: one byte per cycle while the queue has room; an item with a payload
//   byte and a status report leaves as two results from the single-read result queue
// reset: arst_n clears the parser state, the input stage and the queue at once
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// decodes a chunked transfer body byte by byte, emits payload and end status
// ----------------------------------------------------------------------------
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,  // body_byte
	input  logic                   s_axis_tuser,  // byte_present
	input  logic                   s_axis_tlast,  // end_of_body
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // payload_byte, decode_status, decoded_length
	output logic                   m_axis_tuser,  // item_kind
	output logic                   m_axis_tlast   // last_result
);

	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              pres_s1;
	logic              eob_s1;
	logic              room;
	logic              fire;
	push_t             push;
	res_t              res;

	assign fire          = v_s1 && room;
	assign s_axis_tready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			pres_s1 <= s_axis_tuser;
			eob_s1  <= s_axis_tlast;
		end
	end

	hcbd_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.body_byte   (byte_s1),
		.byte_present(pres_s1),
		.end_of_body (eob_s1),
		.push        (push)
	);

	hcbd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res)
	);

	assign m_axis_tdata = OUT_TDATA_W'({res.length, res.status, res.payload});
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

// ----- tb/hcbd_body_checker.sv -----
// ----------------------------------------------------------------------------
// hcbd_body_checker
// watches both stream channels of the chunked body decoder, predicts the
// payload bytes and end-of-body reports from every accepted request and
// compares each delivered result with the oldest prediction
// ----------------------------------------------------------------------------
module hcbd_body_checker import hcbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,
	input  logic                   s_axis_tuser,
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tuser,
	input  logic                   m_axis_tlast,
	output int                     errors,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		P_HDR_START,
		P_HDR_DIGITS,
		P_EXT,
		P_DATA,
		P_TRAIL,
		P_TRAIL_CR,
		P_DONE,
		P_ERROR
	} parse_phase_t;

	parse_phase_t      phase;
	logic [SIZE_W-1:0] chunk_size;
	logic [SIZE_W-1:0] bytes_left;
	logic [LEN_W-1:0]  emitted;
	res_t              expected_q[$];
	int                err_n;

	// {valid, value}
	function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
		if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'd0;
	endfunction

	function automatic logic end_status();
		case (phase)
			P_HDR_START, P_TRAIL, P_DONE: return 1'b0;
			P_HDR_DIGITS, P_EXT:          return chunk_size != '0;
			default:                      return 1'b1;
		endcase
	endfunction

	task automatic clear_parser();
		phase      = P_HDR_START;
		chunk_size = '0;
		bytes_left = '0;
		emitted    = '0;
	endtask

	task automatic open_header(input logic [BYTE_W-1:0] c);
		logic [4:0] h;
		h = hex_nibble(c);
		if (!h[4]) begin
			phase = P_ERROR;
		end else begin
			chunk_size = SIZE_W'(h[3:0]);
			phase      = P_HDR_DIGITS;
		end
	endtask

	task automatic decode_request(input logic [BYTE_W-1:0] c, input logic present,
		input logic ends);
		logic [4:0] h;
		logic       emit;
		res_t       r;
		emit = 1'b0;
		if (present) begin
			case (phase)
				P_HDR_START: open_header(c);
				P_HDR_DIGITS: begin
					h = hex_nibble(c);
					if (c == CH_CR || c == CH_SEMI) phase = P_EXT;
					else if (!h[4]) phase = P_ERROR;
					else chunk_size = {chunk_size[SIZE_W-5:0], h[3:0]};
				end
				P_EXT: begin
					if (c == CH_LF) begin
						if (chunk_size == '0) begin
							phase = P_DONE;
						end else begin
							bytes_left = chunk_size;
							phase      = P_DATA;
						end
					end
				end
				P_DATA: begin
					bytes_left = bytes_left - 1'b1;
					if (bytes_left == '0) phase = P_TRAIL;
					emit = 1'b1;
				end
				P_TRAIL: begin
					if (c == CH_CR) phase = P_TRAIL_CR;
					else open_header(c);
				end
				P_TRAIL_CR: phase = (c == CH_LF) ? P_HDR_START : P_ERROR;
				default: ;
			endcase
		end
		if (emit) begin
			r         = '0;
			r.kind    = KIND_PAYLOAD;
			r.payload = c;
			expected_q.push_back(r);
			emitted = emitted + 1'b1;
		end
		if (ends) begin
			r        = '0;
			r.kind   = KIND_STATUS;
			r.status = end_status();
			r.length = emitted;
			r.last   = 1'b1;
			expected_q.push_back(r);
			clear_parser();
		end
	endtask

	task automatic compare_result();
		res_t got;
		res_t want;
		got.kind    = m_axis_tuser;
		got.payload = m_axis_tdata[7:0];
		got.status  = m_axis_tdata[8];
		got.length  = m_axis_tdata[40:9];
		got.last    = m_axis_tlast;
		if (expected_q.size() == 0) begin
			err_n++;
			if (err_n <= 10)
				$display("unexpected result: kind %0d byte %02h status %0d len %0d last %0d",
					got.kind, got.payload, got.status, got.length, got.last);
		end else begin
			want = expected_q.pop_front();
			if (got.kind != want.kind || got.payload != want.payload ||
				got.status != want.status || got.length != want.length ||
				got.last != want.last) begin
				err_n++;
				if (err_n <= 10) begin
					$display("mismatch: exp kind %0d byte %02h status %0d len %0d last %0d",
						want.kind, want.payload, want.status, want.length, want.last);
					$display("          got kind %0d byte %02h status %0d len %0d last %0d",
						got.kind, got.payload, got.status, got.length, got.last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_q.delete();
			err_n = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				decode_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				compare_result();
			errors  <= err_n;
			pending <= expected_q.size();
		end
	end

endmodule

// ----- tb/tb_http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// feeds the chunked body decoder a few hand-made bodies covering the error
// and end cases, then random chunked bodies (mostly well formed, some cut
// short or corrupted) with random idle gaps and output stalls; a separate
// checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder import hcbd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int BYTE_TARGET = 1300;
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		logic [BYTE_W-1:0] b;
		logic              p;
		logic              l;
	} body_item_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	int         fail_count;
	int         pending_count;
	int         cycle_cnt = 0;
	int         hold_cnt = 0;
	bit         hold_arm = 1'b0;
	bit         hold_done = 1'b0;
	int         sent_bytes = 0;
	body_item_t body_q[$];

	http_chunked_body_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	hcbd_body_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (fail_count),
		.pending       (pending_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_http_chunked_body_decoder: done, errors");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return $urandom_range(1, 2);
		if (r < 92) return $urandom_range(3, 8);
		return $urandom_range(20, 80);
	endfunction

	// output side: random stalls, calm stretches and one long hold-off
	initial begin : rx_side
		int   stall;
		int   calm;
		int   r;
		logic nxt;
		stall = 0;
		calm  = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_arm && !hold_done) begin
				hold_done = 1'b1;
				hold_cnt  = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				nxt = 1'b0;
			end else if (calm > 0) begin
				calm--;
				nxt = 1'b1;
			end else if (stall > 0) begin
				stall--;
				nxt = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) calm = $urandom_range(50, 200);
				else if (r < 25) stall = gap_len();
				nxt = (stall == 0);
			end
			m_axis_tready <= nxt;
		end
	end

	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) return 8'h30 + d;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 8'd10;
	endfunction

	function automatic logic [BYTE_W-1:0] non_lf_byte();
		logic [BYTE_W-1:0] c;
		c = CH_LF;
		while (c == CH_LF) c = BYTE_W'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic add_item(input logic [BYTE_W-1:0] b, input logic p, input logic l);
		body_item_t it;
		it.b = b;
		it.p = p;
		it.l = l;
		body_q.push_back(it);
	endtask

	task automatic put(input logic [BYTE_W-1:0] b);
		add_item(b, 1'b1, 1'b0);
	endtask

	task automatic put_crlf();
		put(CH_CR);
		put(CH_LF);
	endtask

	// size digits; spill adds high digits that shift out of the 32-bit size
	task automatic put_size(input logic [SIZE_W-1:0] sz, input bit spill);
		int nd;
		nd = 1;
		for (int k = 7; k > 0; k--) begin
			if (sz[4*k +: 4] != 4'd0) begin
				nd = k + 1;
				break;
			end
		end
		if (spill) begin
			nd = 8;
			repeat ($urandom_range(1, 3)) put(hex_char(4'($urandom_range(1, 15))));
		end else if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) put("0");
		end
		for (int k = nd - 1; k >= 0; k--) put(hex_char(sz[4*k +: 4]));
	endtask

	task automatic put_ext();
		if ($urandom_range(0, 99) < 30) begin
			put(CH_SEMI);
			repeat ($urandom_range(0, 6)) put(non_lf_byte());
		end
		put(CH_CR);
		if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) put(non_lf_byte());
		put(CH_LF);
	endtask

	task automatic build_good_body();
		int               r;
		logic [SIZE_W-1:0] sz;
		repeat ($urandom_range(0, 4)) begin
			r = $urandom_range(0, 99);
			if (r < 85) sz = $urandom_range(1, 16);
			else if (r < 97) sz = $urandom_range(17, 64);
			else sz = $urandom_range(65, 300);
			put_size(sz, $urandom_range(0, 99) < 8);
			put_ext();
			repeat (sz) put(BYTE_W'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) < 92) put_crlf();
		end
		if ($urandom_range(0, 99) < 85) begin
			put_size('0, 1'b0);
			put_ext();
			if ($urandom_range(0, 99) < 70) put_crlf();
			if ($urandom_range(0, 99) < 30)
				repeat ($urandom_range(1, 4)) put(BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic finish_body();
		body_item_t it;
		if (body_q.size() == 0 || $urandom_range(0, 99) < 30) begin
			add_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else begin
			it = body_q.pop_back();
			it.l = 1'b1;
			body_q.push_back(it);
		end
	endtask

	task automatic build_random_body();
		int         r;
		int         cut;
		body_item_t it;
		build_good_body();
		r = $urandom_range(0, 99);
		if (r < 25 && body_q.size() > 0) begin
			if (r < 13) begin
				cut = $urandom_range(0, body_q.size() - 1);
				while (body_q.size() > cut) void'(body_q.pop_back());
			end else begin
				cut = $urandom_range(0, body_q.size() - 1);
				body_q[cut].b = BYTE_W'($urandom_range(0, 255));
			end
		end
		if ($urandom_range(0, 99) < 30) begin
			repeat ($urandom_range(1, 3)) begin
				it.b = BYTE_W'($urandom_range(0, 255));
				it.p = 1'b0;
				it.l = 1'b0;
				body_q.insert($urandom_range(0, body_q.size()), it);
			end
		end
		finish_body();
	endtask

	task automatic send_item(input body_item_t it, input bit quiet);
		int g;
		g = 0;
		if (!quiet && hold_cnt == 0 && $urandom_range(0, 99) >= 65) g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= it.b;
		s_axis_tuser  <= it.p;
		s_axis_tlast  <= it.l;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		if (it.p) sent_bytes++;
	endtask

	task automatic send_body();
		bit quiet;
		quiet = ($urandom_range(0, 4) == 0);
		foreach (body_q[i]) send_item(body_q[i], quiet);
		body_q.delete();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// bad header start
		add_item(CH_SEMI, 1'b1, 1'b1);
		send_body();
		add_item(CH_CR, 1'b1, 1'b1);
		send_body();
		// non-hex digit, later bytes ignored, end-only request
		put("1");
		put("G");
		put(8'hFF);
		add_item(8'hFF, 1'b0, 1'b1);
		send_body();
		// end inside a header, zero and nonzero size, end with no bytes at all
		add_item("0", 1'b1, 1'b1);
		send_body();
		add_item("5", 1'b1, 1'b1);
		send_body();
		add_item(8'h00, 1'b0, 1'b1);
		send_body();
		// extreme payload bytes, end right after the data
		put("2");
		put_crlf();
		put(8'h00);
		add_item(8'hFF, 1'b1, 1'b1);
		send_body();
		// truncated chunk
		put("3");
		put_crlf();
		add_item("A", 1'b1, 1'b1);
		send_body();
		// CR without LF after the data, body ends after the CR
		put("1");
		put_crlf();
		put(8'h5A);
		add_item(CH_CR, 1'b1, 1'b1);
		send_body();
		// bytes after the zero chunk are ignored
		put("0");
		put_crlf();
		add_item("Z", 1'b1, 1'b1);
		send_body();

		hold_arm = 1'b1;
		while (sent_bytes < BYTE_TARGET) begin
			build_random_body();
			send_body();
		end
		s_axis_tvalid <= 1'b0;

		do @(posedge clk); while (pending_count != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_http_chunked_body_decoder: done, clean");
		end else begin
			$display("tb_http_chunked_body_decoder: done, errors");
		end
		$finish;
	end

endmodule
